// ----- rtl/regex_structure_checker_assert.svh -----
// Assertion macros of the regex structure checker RTL.
`ifndef REGEX_STRUCTURE_CHECKER_ASSERT_SVH
`define REGEX_STRUCTURE_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("regex structure checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("regex structure checker assertion failed");

`endif

// ----- rtl/regsc_pkg.sv -----
// Shared types and constants of the regex structure checker.
package regsc_pkg;

    // Beat types on the external channels.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic        simple;
        logic        balanced;
        logic [15:0] nesting_depth;
        logic [15:0] bar_count;
        logic        long_part;
    } out_beat_t;

    // Pattern bytes that carry structure.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Structural operation of one character as seen by the back end.
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_POPEN  = 3'd1;
    localparam logic [2:0] OP_PCLOSE = 3'd2;
    localparam logic [2:0] OP_BOPEN  = 3'd3;
    localparam logic [2:0] OP_BCLOSE = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic       bar;
        logic       last;
    } tok_t;

    // Limit registers as seen by the back end.
    typedef struct packed {
        logic [15:0] depth_limit;
        logic [15:0] bar_limit;
        logic [15:0] part_limit;
    } cfg_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DEPTH_LIMIT = 2'd0;
    localparam logic [1:0] REG_BAR_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PART_LIMIT  = 2'd2;

    localparam logic [15:0] DEPTH_LIMIT_RST = 16'd5;
    localparam logic [15:0] BAR_LIMIT_RST   = 16'd20;
    localparam logic [15:0] PART_LIMIT_RST  = 16'd1000;

    // Width of the parenthesis and brace levels.
    localparam int LEVEL_W = 17;

    // Queue depths; both must be powers of two, at least two.
    localparam int TOK_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

endpackage

// ----- rtl/regsc_fifo.sv -----
// Small first-in first-out queue of flip-flops with a combinational head.
module regsc_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/regsc_front.sv -----
// Front end: accepts pattern characters and reduces them to structural tokens.
module regsc_front
    import regsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_beat_t item,
    output logic     full,
    input  logic     tok_full,
    output logic     tok_push,
    output tok_t     tok
);

    logic esc_reg;
    logic esc_next;
    logic class_reg;
    logic class_next;
    logic prev_bs_reg;
    logic prev_bs_next;

    assign full     = tok_full;
    assign tok_push = push && !tok_full;

    always_comb
    begin
        esc_next     = esc_reg;
        class_next   = class_reg;
        prev_bs_next = (item.ch == CH_BSLASH);
        tok.op       = OP_NONE;
        tok.bar      = (item.ch == CH_BAR);
        tok.last     = item.last;
        // The character after an unescaped backslash has no structural meaning.
        if (esc_reg)
        begin
            esc_next = 1'b0;
        end
        else
        begin
            case (item.ch)
                CH_BSLASH: esc_next = 1'b1;
                CH_LBRACK: class_next = 1'b1;
                CH_RBRACK:
                begin
                    if (class_reg && !prev_bs_reg)
                    begin
                        class_next = 1'b0;
                    end
                end
                CH_LPAREN: tok.op = class_reg ? OP_NONE : OP_POPEN;
                CH_RPAREN: tok.op = class_reg ? OP_NONE : OP_PCLOSE;
                CH_LBRACE: tok.op = class_reg ? OP_NONE : OP_BOPEN;
                CH_RBRACE: tok.op = class_reg ? OP_NONE : OP_BCLOSE;
                default:   tok.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= 1'b0;
            class_reg   <= 1'b0;
            prev_bs_reg <= 1'b0;
        end
        else if (tok_push)
        begin
            if (item.last)
            begin
                esc_reg     <= 1'b0;
                class_reg   <= 1'b0;
                prev_bs_reg <= 1'b0;
            end
            else
            begin
                esc_reg     <= esc_next;
                class_reg   <= class_next;
                prev_bs_reg <= prev_bs_next;
            end
        end
    end

endmodule

// ----- rtl/regsc_back.sv -----
// Back end: level, depth, bar and part-length counters and the final verdict.
module regsc_back
    import regsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      tok_empty,
    input  tok_t      tok_head,
    output logic      tok_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_beat_t res
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > LEVEL_W) ? CW : LEVEL_W;
    localparam logic [CW-1:0]      CNT_MAX = '1;
    localparam logic [LEVEL_W-1:0] LVL_MAX = '1;

    logic [LEVEL_W-1:0] paren_reg;
    logic [LEVEL_W-1:0] paren_next;
    logic [LEVEL_W-1:0] paren_inc;
    logic [LEVEL_W-1:0] brace_reg;
    logic [LEVEL_W-1:0] brace_next;
    logic               neg_reg;
    logic               neg_next;
    logic [CW-1:0]      depth_reg;
    logic [CW-1:0]      depth_next;
    logic [CW-1:0]      bars_reg;
    logic [CW-1:0]      bars_next;
    logic [CW-1:0]      part_reg;
    logic [CW-1:0]      part_next;
    logic               long_reg;
    logic               long_next;
    logic               bal;

    // A token that ends a pattern waits until the result queue has room.
    assign tok_pop  = !tok_empty && (!tok_head.last || !res_full);
    assign res_push = tok_pop && tok_head.last;

    always_comb
    begin
        paren_next = paren_reg;
        brace_next = brace_reg;
        neg_next   = neg_reg;
        depth_next = depth_reg;
        paren_inc  = (paren_reg == LVL_MAX) ? paren_reg : LEVEL_W'(paren_reg + 1'b1);
        case (tok_head.op)
            OP_POPEN:
            begin
                paren_next = paren_inc;
                if (CMP_W'(paren_inc) > CMP_W'(depth_reg))
                begin
                    depth_next = (CMP_W'(paren_inc) > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                                       : CW'(paren_inc);
                end
            end
            OP_PCLOSE:
            begin
                if (paren_reg == '0)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    paren_next = LEVEL_W'(paren_reg - 1'b1);
                end
            end
            OP_BOPEN:
            begin
                brace_next = (brace_reg == LVL_MAX) ? brace_reg
                                                    : LEVEL_W'(brace_reg + 1'b1);
            end
            OP_BCLOSE:
            begin
                if (brace_reg == '0)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    brace_next = LEVEL_W'(brace_reg - 1'b1);
                end
            end
            default:
            begin
                paren_next = paren_reg;
            end
        endcase

        // Every bar counts, escaped or not, and starts a new alternative.
        bars_next = bars_reg;
        part_next = part_reg;
        long_next = long_reg;
        if (tok_head.bar)
        begin
            bars_next = (bars_reg == CNT_MAX) ? bars_reg : CW'(bars_reg + 1'b1);
            part_next = '0;
        end
        else
        begin
            part_next = (part_reg == CNT_MAX) ? part_reg : CW'(part_reg + 1'b1);
            if (CMP_W'(part_next) > CMP_W'(cfg.part_limit))
            begin
                long_next = 1'b1;
            end
        end

        bal = !neg_next && (paren_next == '0) && (brace_next == '0);
        res.balanced      = bal;
        res.long_part     = long_next;
        res.nesting_depth = 16'(depth_next);
        res.bar_count     = 16'(bars_next);
        res.simple        = bal && !long_next
                            && (CMP_W'(depth_next) <= CMP_W'(cfg.depth_limit))
                            && (CMP_W'(bars_next) <= CMP_W'(cfg.bar_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paren_reg <= '0;
            brace_reg <= '0;
            neg_reg   <= 1'b0;
            depth_reg <= '0;
            bars_reg  <= '0;
            part_reg  <= '0;
            long_reg  <= 1'b0;
        end
        else if (tok_pop)
        begin
            if (tok_head.last)
            begin
                paren_reg <= '0;
                brace_reg <= '0;
                neg_reg   <= 1'b0;
                depth_reg <= '0;
                bars_reg  <= '0;
                part_reg  <= '0;
                long_reg  <= 1'b0;
            end
            else
            begin
                paren_reg <= paren_next;
                brace_reg <= brace_next;
                neg_reg   <= neg_next;
                depth_reg <= depth_next;
                bars_reg  <= bars_next;
                part_reg  <= part_next;
                long_reg  <= long_next;
            end
        end
    end

endmodule

// ----- rtl/regex_structure_checker.sv -----
// Top level of the regex structure checker: queues, limit registers, assertions.
//
//  Channel   Handshake           Beat
//  --------  ------------------  ------------------------------------------------
//  input     push / full         one pattern character and its last mark
//  result    empty / pop         verdict and details, one per pattern
//  config    APB psel/penable    depth, bar and part-length limits at 0x0, 0x4, 0x8
//
// A character beat is accepted in any cycle the token queue has room, so the
// block takes one character per clock cycle. The front end classifies a
// character in the cycle it is accepted and writes its token into the token
// queue; the back end consumes one token per cycle unless it stalls, and a
// verdict passes through the token queue and the result queue before it is
// on the result ports. Reset clears the tracking state, empties both queues
// and loads the limit registers with 5, 20 and 1000; no clearing pass follows.
// The back end stalls only on the last token of a pattern while the result
// queue is full; the token queue then fills and full holds off the sender.
`include "regex_structure_checker_assert.svh"

module regex_structure_checker
    import regsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Character input, queue style.
    input  logic        push,
    input  in_beat_t    item,
    output logic        full,
    // Result output, queue style.
    output logic        empty,
    input  logic        pop,
    output out_beat_t   result,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg_reg;
    logic      cfg_wr;
    logic      tok_full;
    logic      tok_push;
    tok_t      tok_in;
    logic      tok_empty;
    logic      tok_pop;
    tok_t      tok_head;
    logic      res_full;
    logic      res_push;
    out_beat_t res_in;

    // Limit registers. Writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_limit <= DEPTH_LIMIT_RST;
            cfg_reg.bar_limit   <= BAR_LIMIT_RST;
            cfg_reg.part_limit  <= PART_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DEPTH_LIMIT: cfg_reg.depth_limit <= pwdata[15:0];
                REG_BAR_LIMIT:   cfg_reg.bar_limit   <= pwdata[15:0];
                REG_PART_LIMIT:  cfg_reg.part_limit  <= pwdata[15:0];
                default:         cfg_reg.depth_limit <= cfg_reg.depth_limit;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DEPTH_LIMIT: prdata = {16'd0, cfg_reg.depth_limit};
            REG_BAR_LIMIT:   prdata = {16'd0, cfg_reg.bar_limit};
            REG_PART_LIMIT:  prdata = {16'd0, cfg_reg.part_limit};
            default:         prdata = 32'd0;
        endcase
    end

    // The front end tracks escapes and character classes and turns each
    // character into a token: a paren or brace operation, a bar flag and
    // the last mark.
    regsc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .tok_full (tok_full),
        .tok_push (tok_push),
        .tok      (tok_in)
    );

    // The token queue decouples the front end from the back end.
    regsc_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (TOK_QUEUE_DEPTH)
    ) u_tok_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .wdata (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .rdata (tok_head),
        .empty (tok_empty)
    );

    // The back end keeps the counters and forms the verdict on the last token.
    regsc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_empty (tok_empty),
        .tok_head  (tok_head),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // The result queue holds finished verdicts until the consumer pops them.
    regsc_fifo #(
        .WIDTH ($bits(out_beat_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // A simple verdict is never given to an unbalanced pattern or a long part.
    `RSC_ASSERT_IMPL(a_simple_ok, clk, rst_n, !empty && result.simple, result.balanced && !result.long_part)
    // Verdicts are produced only when the last token of a pattern is consumed.
    `RSC_ASSERT_IMPL(a_result_from_last, clk, rst_n, res_push, tok_pop && tok_head.last)
    // A verdict entering the result queue is visible in the next cycle.
    `RSC_ASSERT_NEXT(a_result_visible, clk, rst_n, res_push, !empty)

endmodule

// ----- dv/tb_regex_structure_checker.sv -----
// Testbench for the regex structure checker: streams patterns, predicts and checks verdicts.
`timescale 1ns / 100ps

module tb_regex_structure_checker;
    import regsc_pkg::*;

    localparam logic [16:0] LEVEL_TOP = 17'h1FFFF;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    // Characters sent in each random phase before it may end.
    localparam int PHASE_CHARS = 104;

    // Verdict predictor and store of verdicts still owed by the block.
    class regex_verdict_board;
        logic [15:0] depth_lim = DEPTH_LIMIT_RST;
        logic [15:0] bar_lim   = BAR_LIMIT_RST;
        logic [15:0] part_lim  = PART_LIMIT_RST;

        bit          esc_pending, in_cls, prev_bslash, underflow, part_long;
        logic [16:0] paren_lvl, brace_lvl;
        logic [15:0] depth_peak, bars, part_len;

        out_beat_t   verdicts[$];
        int unsigned errors;

        function new();
            clear();
        endfunction

        function void clear();
            esc_pending = 0;
            in_cls      = 0;
            prev_bslash = 0;
            underflow   = 0;
            part_long   = 0;
            paren_lvl   = '0;
            brace_lvl   = '0;
            depth_peak  = '0;
            bars        = '0;
            part_len    = '0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_DEPTH_LIMIT: depth_lim = val;
                REG_BAR_LIMIT:   bar_lim   = val;
                REG_PART_LIMIT:  part_lim  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // Advances the tracking state by one accepted character and, on the
        // last character, queues the verdict and starts a fresh pattern.
        function void note_char(in_beat_t b);
            out_beat_t v;
            logic      bal;

            // The byte after an unescaped backslash has no structural meaning.
            if (esc_pending)
            begin
                esc_pending = 0;
            end
            else
            begin
                case (b.ch)
                    CH_BSLASH: esc_pending = 1;
                    CH_LBRACK: in_cls = 1;
                    // A raw backslash just before keeps the class open, even
                    // when that backslash was itself escaped.
                    CH_RBRACK: if (in_cls && !prev_bslash) in_cls = 0;
                    CH_LPAREN:
                        if (!in_cls)
                        begin
                            if (paren_lvl != LEVEL_TOP) paren_lvl++;
                            if (paren_lvl > {1'b0, depth_peak})
                                depth_peak = (paren_lvl > {1'b0, COUNT_TOP}) ?
                                             COUNT_TOP : paren_lvl[15:0];
                        end
                    CH_RPAREN:
                        if (!in_cls)
                        begin
                            if (paren_lvl == '0) underflow = 1;
                            else paren_lvl--;
                        end
                    CH_LBRACE:
                        if (!in_cls && brace_lvl != LEVEL_TOP) brace_lvl++;
                    CH_RBRACE:
                        if (!in_cls)
                        begin
                            if (brace_lvl == '0) underflow = 1;
                            else brace_lvl--;
                        end
                    default: ;
                endcase
            end
            prev_bslash = (b.ch == CH_BSLASH);

            // Bars are counted everywhere, escaped or inside a class.
            if (b.ch == CH_BAR)
            begin
                if (bars != COUNT_TOP) bars++;
                part_len = '0;
            end
            else
            begin
                if (part_len != COUNT_TOP) part_len++;
                if (part_len > part_lim) part_long = 1;
            end

            if (b.last)
            begin
                bal             = !underflow && paren_lvl == '0 && brace_lvl == '0;
                v.balanced      = bal;
                v.simple        = bal && depth_peak <= depth_lim && bars <= bar_lim &&
                                  !part_long;
                v.nesting_depth = depth_peak;
                v.bar_count     = bars;
                v.long_part     = part_long;
                verdicts        = {verdicts, v};
                clear();
            end
        endfunction

        function void check_result(out_beat_t r);
            out_beat_t e;
            if (verdicts.size() == 0)
            begin
                $error("result: no verdict expected, got %p", r);
                errors++;
                return;
            end
            e = verdicts.pop_front();
            if (r.simple !== e.simple)
            begin
                $error("simple: expected %0d, got %0d", e.simple, r.simple);
                errors++;
            end
            if (r.balanced !== e.balanced)
            begin
                $error("balanced: expected %0d, got %0d", e.balanced, r.balanced);
                errors++;
            end
            if (r.nesting_depth !== e.nesting_depth)
            begin
                $error("nesting_depth: expected %0d, got %0d",
                       e.nesting_depth, r.nesting_depth);
                errors++;
            end
            if (r.bar_count !== e.bar_count)
            begin
                $error("bar_count: expected %0d, got %0d", e.bar_count, r.bar_count);
                errors++;
            end
            if (r.long_part !== e.long_part)
            begin
                $error("long_part: expected %0d, got %0d", e.long_part, r.long_part);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    in_beat_t    item;
    logic        full;
    logic        empty;
    logic        pop;
    out_beat_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    regex_verdict_board sb = new();

    // Random idling on both channels; switched off for the final stretch.
    bit          idle_on = 1'b1;
    int unsigned chars_sent;

    // Pattern under construction for the random part.
    logic [7:0]  pattern_q[$];

    regex_structure_checker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop. A run of about a thousand characters needs well under a
    // tenth of this even with the longest gaps and stalls on both sides.
    initial
    begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: pop is changed at the falling edge, with random stall
    // bursts. A beat is taken at a rising edge where
    // pop is high and empty is low, and is checked right there.
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty) sb.check_result(result);
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Presents one character and holds it until the block takes it. push is
    // left high afterwards so that back-to-back characters stream at full
    // rate; a gap, when drawn, lowers it from the next falling edge for the gap's length.
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= '{ch: c, last: lst};
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_char(item);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_pattern();
        for (int i = 0; i < pattern_q.size(); i++)
            send_char(pattern_q[i], i == pattern_q.size() - 1);
    endtask

    // Waits until every owed verdict has come back, then lets the pipeline
    // settle before the limits may be touched.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. The upper half
    // of the data word is random; the registers are only 16 bits wide.
    task automatic write_limit(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_limit(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(input logic [15:0] d, input logic [15:0] b,
                              input logic [15:0] p);
        write_limit(REG_DEPTH_LIMIT, d);
        write_limit(REG_BAR_LIMIT, b);
        write_limit(REG_PART_LIMIT, p);
    endtask

    function automatic logic [7:0] any_special();
        case ($urandom_range(0, 7))
            0: return CH_BSLASH;
            1: return CH_LBRACK;
            2: return CH_RBRACK;
            3: return CH_LPAREN;
            4: return CH_RPAREN;
            5: return CH_LBRACE;
            6: return CH_RBRACE;
            default: return CH_BAR;
        endcase
    endfunction

    function automatic logic [7:0] any_letter();
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    // Appends one byte to the pattern under construction.
    function automatic void add_byte(logic [7:0] b);
        pattern_q = {pattern_q, b};
    endfunction

    // Builds the next random pattern. Most are well formed: nested groups,
    // counted braces, classes and escapes with random content, closed in
    // order at the end. One in ten is pure noise over all byte values, and
    // one in ten is well formed with one byte replaced by a structural one.
    function automatic void make_pattern();
        int         kind;
        int         n;
        int         pos;
        logic [7:0] closers[$];

        pattern_q.delete();
        kind = $urandom_range(0, 9);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);

        if (kind == 0)
        begin
            repeat (n)
                add_byte($urandom_range(0, 1) ? any_special() : 8'($urandom_range(0, 255)));
            return;
        end

        while (pattern_q.size() < n)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    add_byte(CH_LPAREN);
                    closers = {closers, CH_RPAREN};
                end
                1:
                begin
                    if (closers.size() != 0)
                    begin
                        add_byte(closers[$]);
                        closers.delete(closers.size() - 1);
                    end
                    else
                    begin
                        add_byte(any_letter());
                    end
                end
                2:
                begin
                    add_byte(CH_LBRACE);
                    add_byte(8'(8'h30 + $urandom_range(0, 9)));
                    closers = {closers, CH_RBRACE};
                end
                3:
                begin
                    add_byte(CH_LBRACK);
                    repeat ($urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            add_byte(CH_BSLASH);
                            add_byte(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            add_byte($urandom_range(0, 2) == 0 ? any_special() : any_letter());
                        end
                    end
                    add_byte(CH_RBRACK);
                end
                4:
                begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                5: add_byte(CH_BAR);
                default: add_byte(any_letter());
            endcase
        end
        while (closers.size() != 0)
        begin
            add_byte(closers[$]);
            closers.delete(closers.size() - 1);
        end

        if (kind == 1)
        begin
            pos = $urandom_range(0, pattern_q.size() - 1);
            pattern_q[pos] = any_special();
        end
    endfunction

    // Stimulus. After reset the directed patterns run under the reset limits.
    // The random part follows in phases, each under its own limits: the reset
    // values, all zero, all at the top, then small random limits so that
    // depth, bar and part violations are frequent. The final phase runs
    // without any idling.
    initial
    begin
        int          phase;
        int unsigned phase_start;

        rst_n      = 1'b0;
        push       = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        chars_sent = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A one-character pattern.
        send_text("a");
        // A close before any open latches the pattern as unbalanced for good.
        send_text(")(");
        send_text("}{");
        // Parentheses inside a class do not count.
        send_text("[(]");
        // The escaped backslash still keeps the class open, so the paren is inert.
        send_text("[\\\\](");
        // An escaped paren has no effect; an escaped bar still counts.
        send_text("\\(\\|");
        // A bar inside a class counts, and braces balance.
        send_text("[|]{}");
        // Extreme byte values.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        drain();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: ;
                1: set_limits(16'd0, 16'd0, 16'd0);
                2: set_limits(COUNT_TOP, COUNT_TOP, COUNT_TOP);
                default: set_limits(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                                    16'($urandom_range(2, 16)));
            endcase
            if (phase == 7) idle_on = 1'b0;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                make_pattern();
                send_pattern();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
